// File: hw/rtl/adaptive_length_integer_codec_defines.svh
// Assertion macros shared by the codec RTL.
// Each macro takes a label, a clock, a reset and a property or condition.
`ifndef ADAPTIVE_LENGTH_INTEGER_CODEC_DEFINES_SVH
`define ADAPTIVE_LENGTH_INTEGER_CODEC_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ALIC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("codec assertion failed");
`define ALIC_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("codec forbidden condition seen");
`else
`define ALIC_ASSERT(label, clk, rst, prop)
`define ALIC_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// File: hw/rtl/alic_pkg.sv
package alic_pkg;

   // item kinds
   localparam logic KIND_ENCODE = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   // forms; the unused fourth code behaves as the long form
   localparam logic [1:0] FMT_SHORT = 2'd0;
   localparam logic [1:0] FMT_MID   = 2'd1;
   localparam logic [1:0] FMT_LONG  = 2'd2;

   localparam int unsigned VALUE_W   = 62;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned ACC_W     = 64;
   localparam int unsigned SHORT_W   = 15;
   localparam int unsigned MID_W     = 30;
   // value thresholds for one, two, three and four byte runs
   localparam int unsigned LIM_ONE   = 6;
   localparam int unsigned LIM_TWO   = 1 * 8 + 6;
   localparam int unsigned LIM_THREE = 2 * 8 + 6;
   localparam int unsigned LIM_FOUR  = 3 * 8 + 6;

   typedef struct packed {
      logic               kind;
      logic [1:0]         format;
      logic [VALUE_W-1:0] value_in;
      logic [BYTE_W-1:0]  byte_in;
   } item_type;

   typedef struct packed {
      logic [2:0]        count_m1;
      logic [BYTE_W-1:0] data;
      logic              too_large;
   } enc_result_type;

   typedef struct packed {
      logic              step;
      logic [1:0]        format;
      logic [BYTE_W-1:0] data;
   } dec_request_type;

   typedef struct packed {
      logic               emit;
      logic [VALUE_W-1:0] value;
   } dec_result_type;

   // map the unused format code onto the long form
   function automatic logic [1:0] norm_format(input logic [1:0] f);
      norm_format = (f == FMT_SHORT || f == FMT_MID) ? f : FMT_LONG;
   endfunction

   // run length minus one from the form and the tag bits of the first byte
   function automatic logic [2:0] run_len_m1(input logic [1:0] f, input logic [1:0] tag);
      logic [2:0] r;
      r = 3'd0;
      case (f)
         FMT_SHORT: r = {2'b00, tag[0]};
         FMT_MID:   r = {1'b0, tag};
         default: begin
            case (tag)
               2'd0:    r = 3'd0;
               2'd1:    r = 3'd1;
               2'd2:    r = 3'd3;
               default: r = 3'd7;
            endcase
         end
      endcase
      run_len_m1 = r;
   endfunction

endpackage

// File: hw/rtl/adaptive_length_integer_codec.sv
// Adaptive-length integer codec, byte count in the low tag bits.
// Input channel req_*: an encode item (kind 0) carries a value and a form; a
// decode item (kind 1) carries one byte of an encoded run and, on the run's
// first byte, its form. Result channel rsp_*: encoded bytes least significant
// first with tlast on the final one, or one decoded value per finished run.
// An accepted item is written into the holding register, or into the spare
// input entry while the holding register is busy; each result is registered
// in the result register before it is presented on rsp_tvalid.
// An encode item stays in the holding register, where the byte serializer
// sends its output bytes (1 to 8, set by the value and the form) one at a
// time as the result register frees; a decode item leaves once it is sent.
// A two-entry input buffer keeps req_tready registered, so the next item is
// taken while a finished result waits on rsp_tready.
// Reset clears the decode state, the buffers and rsp_tvalid. When the receiver
// stalls, the result register holds its item and the holding stage waits;
// req_tready drops once the spare input entry is full.
`include "adaptive_length_integer_codec_defines.svh"
module adaptive_length_integer_codec
   import alic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // value_in[61:0], byte_in[69:62], zero pad
   input  logic [2:0]  req_tuser,   // kind[0], format[2:1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // byte_out[7:0], value_out[69:8], zero pad
   output logic [1:0]  rsp_tuser,   // is_value[0], too_large[1]
   output logic        rsp_tlast
);

   item_type           req_item;
   item_type           hold_item_ff, hold_item_in;
   item_type           skid_item_ff, skid_item_in;
   logic               hold_valid_ff, hold_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [2:0]         index_ff, index_in;
   logic               accept;
   logic               out_free;
   logic               fire;
   logic               hold_done;
   logic               hold_take;
   enc_result_type     enc;
   dec_request_type    dec_req;
   dec_result_type     dec_rsp;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               is_value_ff, is_value_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               last_ff, last_in;
   logic               too_large_ff, too_large_in;

   // unpack the input item
   assign req_item.kind     = req_tuser[0];
   assign req_item.format   = req_tuser[2:1];
   assign req_item.value_in = req_tdata[VALUE_W-1:0];
   assign req_item.byte_in  = req_tdata[VALUE_W+BYTE_W-1:VALUE_W];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   // holding stage advance
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign fire      = hold_valid_ff && out_free;
   assign hold_done = fire && (hold_item_ff.kind == KIND_DECODE || index_ff == enc.count_m1);
   assign hold_take = !hold_valid_ff || hold_done;

   alic_enc u_enc (
      .value  (hold_item_ff.value_in),
      .format (hold_item_ff.format),
      .index  (index_ff),
      .result (enc)
   );

   assign dec_req.step   = fire && hold_item_ff.kind == KIND_DECODE;
   assign dec_req.format = hold_item_ff.format;
   assign dec_req.data   = hold_item_ff.byte_in;

   alic_dec u_dec (
      .clock (clock),
      .reset (reset),
      .req   (dec_req),
      .rsp   (dec_rsp)
   );

   // input buffer and holding register
   always_comb begin
      hold_item_in  = hold_item_ff;
      hold_valid_in = hold_valid_ff;
      skid_item_in  = skid_item_ff;
      skid_valid_in = skid_valid_ff;
      index_in      = index_ff;
      if (hold_take) begin
         index_in = 3'd0;
         if (skid_valid_ff) begin
            hold_item_in  = skid_item_ff;
            hold_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            hold_item_in  = req_item;
            hold_valid_in = accept;
         end
      end else begin
         if (fire) begin
            index_in = index_ff + 3'd1;
         end
         if (accept) begin
            skid_item_in  = req_item;
            skid_valid_in = 1'b1;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      is_value_in  = is_value_ff;
      byte_in      = byte_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      too_large_in = too_large_ff;
      if (fire && hold_item_ff.kind == KIND_ENCODE) begin
         rsp_valid_in = 1'b1;
         is_value_in  = 1'b0;
         byte_in      = enc.data;
         value_in     = '0;
         last_in      = (index_ff == enc.count_m1);
         too_large_in = enc.too_large;
      end else if (dec_rsp.emit) begin
         rsp_valid_in = 1'b1;
         is_value_in  = 1'b1;
         byte_in      = '0;
         value_in     = dec_rsp.value;
         last_in      = 1'b0;
         too_large_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
         index_ff      <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         skid_valid_ff <= skid_valid_in;
         index_ff      <= index_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_item_ff <= hold_item_in;
      skid_item_ff <= skid_item_in;
      is_value_ff  <= is_value_in;
      byte_ff      <= byte_in;
      value_ff     <= value_in;
      last_ff      <= last_in;
      too_large_ff <= too_large_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, value_ff, byte_ff};
   assign rsp_tuser  = {too_large_ff, is_value_ff};
   assign rsp_tlast  = last_ff;

   `ALIC_ASSERT(a_spare_needs_hold, clock, reset, skid_valid_ff |-> hold_valid_ff)
   `ALIC_ASSERT(a_index_in_run, clock, reset,
                (hold_valid_ff && hold_item_ff.kind == KIND_ENCODE) |-> index_ff <= enc.count_m1)
   `ALIC_ASSERT_NEVER(a_value_has_no_byte_marks, clock, reset,
                      rsp_valid_ff && is_value_ff && (last_ff || too_large_ff))
   `ALIC_ASSERT(a_reset_clears_result, clock, reset, $past(reset) |-> !rsp_valid_ff)

endmodule

// File: hw/rtl/alic_enc.sv
// Encoder: builds the code word of the held value and picks byte k of it.
module alic_enc
   import alic_pkg::*;
(
   input  logic [VALUE_W-1:0] value,
   input  logic [1:0]         format,
   input  logic [2:0]         index,
   output enc_result_type     result
);

   logic [1:0]       fmt;
   logic [ACC_W-1:0] code;
   logic [2:0]       count_m1;
   logic             too_large;
   logic [1:0]       tag;

   assign fmt = norm_format(format);

   // code word, byte count and overflow flag per form
   always_comb begin
      code      = '0;
      count_m1  = 3'd0;
      too_large = 1'b0;
      tag       = 2'd0;
      case (fmt)
         FMT_SHORT: begin
            count_m1  = {2'b00, |value[SHORT_W-1:7]};
            code      = {{(ACC_W-SHORT_W-1){1'b0}}, value[SHORT_W-1:0], count_m1[0]};
            too_large = |value[VALUE_W-1:SHORT_W];
         end
         FMT_MID: begin
            if (value[MID_W-1:LIM_ONE] == '0) begin
               tag = 2'd0;
            end else if (value[MID_W-1:LIM_TWO] == '0) begin
               tag = 2'd1;
            end else if (value[MID_W-1:LIM_THREE] == '0) begin
               tag = 2'd2;
            end else begin
               tag = 2'd3;
            end
            count_m1  = {1'b0, tag};
            code      = {{(ACC_W-MID_W-2){1'b0}}, value[MID_W-1:0], tag};
            too_large = |value[VALUE_W-1:MID_W];
         end
         default: begin
            if (value[VALUE_W-1:LIM_ONE] == '0) begin
               tag = 2'd0;
            end else if (value[VALUE_W-1:LIM_TWO] == '0) begin
               tag = 2'd1;
            end else if (value[VALUE_W-1:LIM_FOUR] == '0) begin
               tag = 2'd2;
            end else begin
               tag = 2'd3;
            end
            count_m1 = run_len_m1(FMT_LONG, tag);
            code     = {value, tag};
         end
      endcase
   end

   assign result.count_m1  = count_m1;
   assign result.data      = code[BYTE_W*index +: BYTE_W];
   assign result.too_large = too_large;

endmodule

// File: hw/rtl/alic_dec.sv
`include "adaptive_length_integer_codec_defines.svh"
// Decoder: gathers one byte per step and reports the value on the run's last byte.
module alic_dec
   import alic_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  dec_request_type req,
   output dec_result_type  rsp
);

   logic [ACC_W-1:0] accumulator_ff, accumulator_in;
   logic [2:0]       bytes_left_ff, bytes_left_in;
   logic [1:0]       active_format_ff, active_format_in;
   logic             decoding_ff, decoding_in;
   logic [2:0]       pos;
   logic             emit;

   // next decode state
   always_comb begin
      accumulator_in   = accumulator_ff;
      bytes_left_in    = bytes_left_ff;
      active_format_in = active_format_ff;
      decoding_in      = decoding_ff;
      pos              = run_len_m1(active_format_ff, accumulator_ff[1:0]) + 3'd1
                         - bytes_left_ff;
      emit             = 1'b0;
      if (req.step) begin
         if (!decoding_ff) begin
            // first byte of a run
            active_format_in = norm_format(req.format);
            accumulator_in   = {{(ACC_W-BYTE_W){1'b0}}, req.data};
            bytes_left_in    = run_len_m1(active_format_in, req.data[1:0]);
            emit             = (bytes_left_in == 3'd0);
            decoding_in      = !emit;
         end else begin
            for (int i = 0; i < ACC_W / BYTE_W; i++) begin
               if (pos == 3'(i)) begin
                  accumulator_in[BYTE_W*i +: BYTE_W] =
                     accumulator_ff[BYTE_W*i +: BYTE_W] | req.data;
               end
            end
            bytes_left_in = bytes_left_ff - 3'd1;
            emit          = (bytes_left_in == 3'd0);
            decoding_in   = !emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accumulator_ff   <= '0;
         bytes_left_ff    <= '0;
         active_format_ff <= FMT_SHORT;
         decoding_ff      <= 1'b0;
      end else begin
         accumulator_ff   <= accumulator_in;
         bytes_left_ff    <= bytes_left_in;
         active_format_ff <= active_format_in;
         decoding_ff      <= decoding_in;
      end
   end

   // strip the tag bits
   assign rsp.emit  = emit;
   assign rsp.value = (active_format_in == FMT_SHORT) ? accumulator_in[VALUE_W:1]
                                                      : accumulator_in[VALUE_W+1:2];

   `ALIC_ASSERT(a_dec_left_tracks_run, clock, reset, decoding_ff == (bytes_left_ff != 3'd0))
   `ALIC_ASSERT(a_dec_emit_ends_run, clock, reset, (req.step && emit) |=> !decoding_ff)
   `ALIC_ASSERT(a_dec_mid_run_continues, clock, reset,
                (decoding_ff && req.step && !emit) |=> decoding_ff)

endmodule
